// ===== rtl/pce_pkg.sv =====
// Shared types and constants for the preamble channel equalizer.
// Used by the top, front, queue and back modules; depends on nothing.
package pce_pkg;

  localparam int NUM_SC   = 64;
  localparam int SC_W     = $clog2(NUM_SC);
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int COEF_F   = COEF_W - 8;
  localparam int COUNT_W  = 11;
  localparam int EST_W    = 10;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int DC_SC    = NUM_SC / 2 + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ESTIMATION_SYMBOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSIENT_SYMBOLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SYMBOLS     = 2'd2;

  typedef struct packed {
    logic [EST_W-1:0]   estimation_symbol;
    logic [EST_W-1:0]   transient_symbols;
    logic [COUNT_W-1:0] frame_symbols;
  } cfg_t;

  typedef enum logic {
    KIND_PAYLOAD,
    KIND_ESTIMATE
  } item_kind_t;

  // classified item handed from front to back
  typedef struct packed {
    item_kind_t                  kind;
    logic [SC_W-1:0]             subcarrier;
    logic signed [SAMPLE_W-1:0]  sample_re;
    logic signed [SAMPLE_W-1:0]  sample_im;
    logic signed [SAMPLE_W-1:0]  reference_re;
    logic signed [SAMPLE_W-1:0]  reference_im;
    logic                        allocated;
  } entry_t;

endpackage

// ===== rtl/preamble_channel_equalizer_top.sv =====
// Preamble channel equalizer, top level. A payload item passes through the back end's
// two-multiplier complex product; the back end takes no new item until the last is out.
// An allocated even estimation carrier with a nonzero sample runs a 24-step serial divider; the last carrier
// of the estimation symbol adds an interpolation pass over the RAM.
// Synchronous reset clears counters, phase, coefficients (read as zero) and map.
// Uses pce_pkg, pce_front, pce_queue, pce_back.
module preamble_channel_equalizer_top import pce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sample_re, sample_im, reference_re, reference_im
  input  logic [63:0]           s_axis_tdata,
  // allocated
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // equalized_re, equalized_im, subcarrier, 2 bits zero
  output logic [39:0]           m_axis_tdata,
  // last_of_symbol
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t   cfg;
  logic   push, q_ready, q_valid, q_pop;
  entry_t push_entry, q_head;
  logic signed [SAMPLE_W-1:0] eq_re, eq_im;
  logic [SC_W-1:0] eq_sc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.estimation_symbol <= EST_W'(8);
      cfg.transient_symbols <= EST_W'(12);
      cfg.frame_symbols     <= COUNT_W'(76);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ESTIMATION_SYMBOL: cfg.estimation_symbol <= cfg_data[EST_W-1:0];
        CFG_TRANSIENT_SYMBOLS: cfg.transient_symbols <= cfg_data[EST_W-1:0];
        CFG_FRAME_SYMBOLS:     cfg.frame_symbols     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  pce_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_data     (s_axis_tdata),
    .in_alloc    (s_axis_tuser[0]),
    .push        (push),
    .push_entry  (push_entry),
    .queue_ready (q_ready)
  );

  pce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  pce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_re    (eq_re),
    .out_im    (eq_im),
    .out_sc    (eq_sc),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, eq_sc, eq_im, eq_re};

endmodule

// ===== rtl/pce_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pce_front.sv =====
// Front end: accepts items, tracks subcarrier/symbol position and frame phase,
// and forwards payload and estimation items. Depends on pce_pkg.
module pce_front import pce_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [4*SAMPLE_W-1:0] in_data,
  input  logic                in_alloc,
  output logic                push,
  output entry_t              push_entry,
  input  logic                queue_ready
);

  logic [SC_W-1:0]    sc_count;
  logic [COUNT_W-1:0] sym_count;
  logic               in_payload;

  logic [COUNT_W-1:0] sym_mid;
  logic               payload_mid;
  logic               payload_now;
  logic               accept;

  assign in_ready = queue_ready;
  assign accept   = in_valid & queue_ready;

  // phase checks at the start of each symbol
  always_comb begin
    sym_mid     = sym_count;
    payload_mid = in_payload;
    if (sc_count == '0) begin
      if (in_payload && sym_count >= cfg.frame_symbols) begin
        sym_mid     = '0;
        payload_mid = 1'b0;
      end
    end
    payload_now = payload_mid;
    if (sc_count == '0 && !payload_mid &&
        sym_mid >= {1'b0, cfg.transient_symbols}) begin
      payload_now = 1'b1;
    end
  end

  // classify
  always_comb begin
    push_entry.kind         = payload_now ? KIND_PAYLOAD : KIND_ESTIMATE;
    push_entry.subcarrier   = sc_count;
    push_entry.sample_re    = in_data[SAMPLE_W-1:0];
    push_entry.sample_im    = in_data[2*SAMPLE_W-1:SAMPLE_W];
    push_entry.reference_re = in_data[3*SAMPLE_W-1:2*SAMPLE_W];
    push_entry.reference_im = in_data[4*SAMPLE_W-1:3*SAMPLE_W];
    push_entry.allocated    = in_alloc;
    push = accept &
           (payload_now | (sym_mid == {1'b0, cfg.estimation_symbol}));
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_count   <= '0;
      sym_count  <= '0;
      in_payload <= 1'b0;
    end else if (accept) begin
      in_payload <= payload_now;
      if (sc_count == SC_W'(NUM_SC - 1)) begin
        sc_count  <= '0;
        sym_count <= (sym_mid == {COUNT_W{1'b1}}) ? sym_mid : sym_mid + 1'b1;
      end else begin
        sc_count  <= sc_count + 1'b1;
        sym_count <= sym_mid;
      end
    end
  end

endmodule

// ===== rtl/pce_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on pce_pkg.
module pce_queue import pce_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   ready,
  input  logic   pop,
  output logic   valid,
  output entry_t head
);

  entry_t      slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/pce_back.sv =====
// Back end: zero-forcing estimation (bit-serial divider), interpolation pass
// over the coefficient RAM, and payload equalization. Depends on pce_pkg, pce_ram.
module pce_back import pce_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  entry_t                     q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_re,
  output logic signed [SAMPLE_W-1:0] out_im,
  output logic [SC_W-1:0]            out_sc,
  output logic                       out_last
);

  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int NUM_W  = 2 * SAMPLE_W + 1;
  localparam int DEN_W  = 2 * SAMPLE_W;
  localparam int INT_B  = COEF_W - 1 - COEF_F;
  localparam int QB     = COEF_W;
  localparam int REM_W  = DEN_W + INT_B + 1;
  localparam int CNT_W  = $clog2(QB);
  localparam int ACC_W  = PROD_W + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_EMUL0, S_EMUL1, S_EMUL2, S_EMUL3, S_DIVSET, S_DIV, S_EFIN,
    S_EWRITE, S_PRD0, S_PRD1, S_PRD2, S_DC0, S_DC1,
    S_PM0, S_PM1, S_PM2, S_POUT
  } state_t;

  state_t state;
  entry_t ent;

  logic signed [PROD_W-1:0] pa, pb;
  logic [DEN_W-1:0]         den;
  logic signed [NUM_W-1:0]  num_re, num_im;
  logic [REM_W-1:0]         r_re, r_im;
  logic [QB-1:0]            t_re, t_im;
  logic                     neg_re, neg_im, sat_re, sat_im;
  logic [CNT_W-1:0]         cnt;
  logic signed [COEF_W-1:0] res_re, res_im;
  logic signed [COEF_W-1:0] left_re, left_im;
  logic signed [COEF_W-1:0] c_re, c_im;
  logic signed [ACC_W-1:0]  acc_re, acc_im;
  logic [SC_W-1:0]          pass_i;
  logic [NUM_SC-1:0]        coef_ok;
  logic [NUM_SC-1:0]        alloc_map;
  logic                     rd_ok;

  // coefficient RAM ports
  logic                  ram_we;
  logic [SC_W-1:0]       ram_waddr, ram_raddr;
  logic [2*COEF_W-1:0]   ram_wdata, ram_rdata;
  logic signed [COEF_W-1:0] rd_re, rd_im;

  pce_ram #(.WIDTH(2 * COEF_W), .DEPTH(NUM_SC)) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entries never written read as zero
  assign rd_re = rd_ok ? ram_rdata[COEF_W-1:0]        : '0;
  assign rd_im = rd_ok ? ram_rdata[2*COEF_W-1:COEF_W] : '0;

  function automatic logic signed [COEF_W-1:0] quot_final(
    input logic [QB-1:0] t, input logic neg, input logic sat);
    logic [QB-1:0] q;
    q = sat ? QB'(1) << (COEF_W - 1) : QB'(t[QB-1:1]) + QB'(t[0]);
    if (q[QB-1]) begin
      quot_final = neg ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      quot_final = neg ? -$signed(q) : $signed(q);
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] sh;
    s  = {a[ACC_W-1], a} + (ACC_W+1)'(1 << (COEF_F - 1));
    sh = s >>> COEF_F;
    if (sh > (ACC_W+1)'((1 << (SAMPLE_W - 1)) - 1)) begin
      round_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sh < -(ACC_W+1)'(1 << (SAMPLE_W - 1))) begin
      round_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      round_sat = sh[SAMPLE_W-1:0];
    end
  endfunction

  // interpolation of one odd carrier
  logic                      both_alloc;
  logic signed [COEF_W:0]    sum_re, sum_im;
  logic signed [COEF_W-1:0]  avg_re, avg_im;
  logic [SC_W-1:0]           pass_lo, pass_hi;
  always_comb begin
    pass_lo    = pass_i - 1'b1;
    pass_hi    = pass_i + 1'b1;
    both_alloc = alloc_map[pass_lo] && (pass_i != SC_W'(NUM_SC - 1)) &&
                 alloc_map[pass_hi];
    sum_re = {left_re[COEF_W-1], left_re} + {rd_re[COEF_W-1], rd_re} + 1'b1;
    sum_im = {left_im[COEF_W-1], left_im} + {rd_im[COEF_W-1], rd_im} + 1'b1;
    avg_re = both_alloc ? sum_re[COEF_W:1] : left_re;
    avg_im = both_alloc ? sum_im[COEF_W:1] : left_im;
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ent.subcarrier;
    ram_wdata = {res_im, res_re};
    ram_raddr = q_head.subcarrier;
    unique case (state)
      S_EWRITE: ram_we = 1'b1;
      S_PRD0:   ram_raddr = pass_lo;
      S_PRD1:   ram_raddr = pass_hi;
      S_PRD2: begin
        ram_we    = alloc_map[pass_i];
        ram_waddr = pass_i;
        ram_wdata = {avg_im, avg_re};
      end
      S_DC0: ram_raddr = SC_W'(DC_SC + 1);
      S_DC1: begin
        ram_we    = alloc_map[DC_SC];
        ram_waddr = SC_W'(DC_SC);
        ram_wdata = {rd_im, rd_re};
      end
      default: ram_raddr = q_head.subcarrier;
    endcase
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      coef_ok   <= '0;
      alloc_map <= '0;
    end else begin
      rd_ok <= coef_ok[ram_raddr];
      // result taken; a new one is loaded only in S_POUT
      if (out_ready && state != S_POUT) out_valid <= 1'b0;
      if (ram_we) coef_ok[ram_waddr] <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            ent <= q_head;
            if (q_head.kind == KIND_PAYLOAD) begin
              state <= S_PM0;
            end else begin
              // new estimation symbol starts from an empty map
              if (q_head.subcarrier == '0) begin
                coef_ok   <= '0;
                alloc_map <= NUM_SC'(q_head.allocated);
              end else begin
                alloc_map[q_head.subcarrier] <= q_head.allocated;
              end
              res_re <= '0;
              res_im <= '0;
              if (!q_head.subcarrier[0] && q_head.allocated &&
                  (q_head.sample_re != '0 || q_head.sample_im != '0)) begin
                state <= S_EMUL0;
              end else begin
                state <= S_EWRITE;
              end
            end
          end
        end
        // |sample|^2 and the two numerators
        S_EMUL0: begin
          pa    <= PROD_W'(ent.sample_re * ent.sample_re);
          pb    <= PROD_W'(ent.sample_im * ent.sample_im);
          state <= S_EMUL1;
        end
        S_EMUL1: begin
          den   <= DEN_W'(pa + pb);
          pa    <= PROD_W'(ent.reference_re * ent.sample_re);
          pb    <= PROD_W'(ent.reference_im * ent.sample_im);
          state <= S_EMUL2;
        end
        S_EMUL2: begin
          num_re <= NUM_W'(pa + pb);
          pa     <= PROD_W'(ent.reference_im * ent.sample_re);
          pb     <= PROD_W'(ent.reference_re * ent.sample_im);
          state  <= S_EMUL3;
        end
        S_EMUL3: begin
          num_im <= NUM_W'(pa - pb);
          state  <= S_DIVSET;
        end
        // integer part of 2^INT_B or more saturates
        S_DIVSET: begin
          neg_re <= num_re[NUM_W-1];
          neg_im <= num_im[NUM_W-1];
          r_re   <= REM_W'(num_re[NUM_W-1] ? DEN_W'(-num_re) : DEN_W'(num_re));
          r_im   <= REM_W'(num_im[NUM_W-1] ? DEN_W'(-num_im) : DEN_W'(num_im));
          sat_re <= REM_W'(num_re[NUM_W-1] ? DEN_W'(-num_re) : DEN_W'(num_re)) >=
                    (REM_W'(den) << INT_B);
          sat_im <= REM_W'(num_im[NUM_W-1] ? DEN_W'(-num_im) : DEN_W'(num_im)) >=
                    (REM_W'(den) << INT_B);
          cnt    <= '0;
          state  <= S_DIV;
        end
        // one quotient bit per cycle for both parts, one extra bit for rounding
        S_DIV: begin
          if (r_re >= (REM_W'(den) << (INT_B - 1))) begin
            r_re <= (r_re - (REM_W'(den) << (INT_B - 1))) << 1;
            t_re <= {t_re[QB-2:0], 1'b1};
          end else begin
            r_re <= r_re << 1;
            t_re <= {t_re[QB-2:0], 1'b0};
          end
          if (r_im >= (REM_W'(den) << (INT_B - 1))) begin
            r_im <= (r_im - (REM_W'(den) << (INT_B - 1))) << 1;
            t_im <= {t_im[QB-2:0], 1'b1};
          end else begin
            r_im <= r_im << 1;
            t_im <= {t_im[QB-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(QB - 1)) state <= S_EFIN;
        end
        S_EFIN: begin
          res_re <= quot_final(t_re, neg_re, sat_re);
          res_im <= quot_final(t_im, neg_im, sat_im);
          state  <= S_EWRITE;
        end
        S_EWRITE: begin
          pass_i <= SC_W'(1);
          state  <= (ent.subcarrier == SC_W'(NUM_SC - 1)) ? S_PRD0 : S_IDLE;
        end
        // interpolation pass over odd carriers
        S_PRD0: state <= S_PRD1;
        S_PRD1: begin
          left_re <= rd_re;
          left_im <= rd_im;
          state   <= S_PRD2;
        end
        S_PRD2: begin
          pass_i <= pass_i + SC_W'(2);
          state  <= (pass_i == SC_W'(NUM_SC - 1)) ? S_DC0 : S_PRD0;
        end
        S_DC0: state <= S_DC1;
        S_DC1: state <= S_IDLE;
        // payload: complex multiply, two products per cycle
        S_PM0: begin
          c_re  <= rd_re;
          c_im  <= rd_im;
          pa    <= PROD_W'(ent.sample_re * rd_re);
          pb    <= PROD_W'(ent.sample_im * rd_im);
          state <= S_PM1;
        end
        S_PM1: begin
          acc_re <= ACC_W'(pa - pb);
          pa     <= PROD_W'(ent.sample_re * c_im);
          pb     <= PROD_W'(ent.sample_im * c_re);
          state  <= S_PM2;
        end
        S_PM2: begin
          acc_im <= ACC_W'(pa + pb);
          state  <= S_POUT;
        end
        S_POUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_re    <= round_sat(acc_re);
            out_im    <= round_sat(acc_im);
            out_sc    <= ent.subcarrier;
            out_last  <= (ent.subcarrier == SC_W'(NUM_SC - 1));
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/tb_preamble_channel_equalizer_top.sv =====
// Self-checking testbench for preamble_channel_equalizer_top.
// Drives subcarrier items through the stream ports and checks each result
// against a cycle-free predictor; depends on pce_pkg and the block's RTL.
module tb_preamble_channel_equalizer_top;
  import pce_pkg::*;

  localparam int QUIET_CYCLES = 200;
  localparam int STALL_LIMIT  = 5000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic [SC_W-1:0]            sc;
    logic                       last;
  } eq_result_t;

  // Predictor of the equalizer plus the queue of results it expects
  class eq_scoreboard;
    longint      coef_re[NUM_SC];
    longint      coef_im[NUM_SC];
    bit          alloc_map[NUM_SC];
    int unsigned sym_cnt, sc_cnt, est_sym, trans_syms, frame_syms;
    bit          payload;
    eq_result_t  pending[$];
    int          errors, results, items;

    function new();
      foreach (coef_re[i]) begin
        coef_re[i] = 0;
        coef_im[i] = 0;
        alloc_map[i] = 0;
      end
      sym_cnt = 0; sc_cnt = 0; payload = 0;
      est_sym = 8; trans_syms = 12; frame_syms = 76;
      errors = 0; results = 0; items = 0;
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
      case (idx)
        CFG_ESTIMATION_SYMBOL: est_sym = v & 'h3FF;
        CFG_TRANSIENT_SYMBOLS: trans_syms = v & 'h3FF;
        CFG_FRAME_SYMBOLS:     frame_syms = v & 'h7FF;
        default: ;
      endcase
    endfunction

    function longint sat(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // floor(v / 2^sh + 1/2)
    function longint round_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // num / den in coefficient format, halves away from zero, saturated
    function longint coef_div(longint num, longint den);
      longint mag, q, r, lim;
      bit neg;
      neg = num < 0;
      mag = neg ? -num : num;
      lim = longint'(1) <<< (COEF_W - 1);
      q = mag / den;
      r = mag % den;
      if (q >= (longint'(1) <<< (COEF_W - 1 - COEF_F))) begin
        q = lim;
      end else begin
        for (int i = 0; i < COEF_F; i++) begin
          q = q << 1;
          r = r << 1;
          if (r >= den) begin
            r -= den;
            q++;
          end
        end
        if ((r << 1) >= den) q++;
      end
      if (neg) return -(q > lim ? lim : q);
      return q > lim - 1 ? lim - 1 : q;
    endfunction

    // fill odd carriers from even neighbors, then the DC carrier from the one above it
    function void fill_odd();
      for (int i = 1; i < NUM_SC; i += 2) begin
        if (!alloc_map[i]) continue;
        if (alloc_map[i-1] && i + 1 < NUM_SC && alloc_map[i+1]) begin
          coef_re[i] = round_shift(coef_re[i-1] + coef_re[i+1], 1);
          coef_im[i] = round_shift(coef_im[i-1] + coef_im[i+1], 1);
        end else begin
          coef_re[i] = coef_re[i-1];
          coef_im[i] = coef_im[i-1];
        end
      end
      if (DC_SC + 1 < NUM_SC && alloc_map[DC_SC]) begin
        coef_re[DC_SC] = coef_re[DC_SC+1];
        coef_im[DC_SC] = coef_im[DC_SC+1];
      end
    endfunction

    function void note_input(logic signed [SAMPLE_W-1:0] s_re, s_im, r_re, r_im,
                             logic alloc);
      longint sr, si, rr, ri, den, er, ei;
      int unsigned k;
      eq_result_t res;
      sr = s_re; si = s_im; rr = r_re; ri = r_im;
      k = sc_cnt;
      items++;
      if (k == 0) begin
        if (payload && sym_cnt >= frame_syms) begin
          sym_cnt = 0;
          payload = 0;
        end
        if (!payload && sym_cnt >= trans_syms) payload = 1;
      end
      if (payload) begin
        er = round_shift(sr * coef_re[k] - si * coef_im[k], COEF_F);
        ei = round_shift(sr * coef_im[k] + si * coef_re[k], COEF_F);
        res.re = SAMPLE_W'(sat(er, SAMPLE_W));
        res.im = SAMPLE_W'(sat(ei, SAMPLE_W));
        res.sc = SC_W'(k);
        res.last = (k == NUM_SC - 1);
        pending.insert(pending.size(), res);
      end else if (sym_cnt == est_sym) begin
        if (k == 0) begin
          foreach (coef_re[i]) begin
            coef_re[i] = 0;
            coef_im[i] = 0;
            alloc_map[i] = 0;
          end
        end
        alloc_map[k] = alloc;
        coef_re[k] = 0;
        coef_im[k] = 0;
        if (k % 2 == 0 && alloc && (sr != 0 || si != 0)) begin
          den = sr * sr + si * si;
          coef_re[k] = coef_div(rr * sr + ri * si, den);
          coef_im[k] = coef_div(ri * sr - rr * si, den);
        end
        if (k == NUM_SC - 1) fill_odd();
      end
      k++;
      if (k >= NUM_SC) begin
        k = 0;
        if (sym_cnt < 2047) sym_cnt++;
      end
      sc_cnt = k;
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] re, im, logic [SC_W-1:0] sc,
                               logic last);
      eq_result_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d sc=%0d last=%0b",
                 $time, re, im, sc, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) begin
        $display("%0t: equalized_re expected %0d actual %0d (sc %0d)", $time, e.re, re, e.sc);
        errors++;
      end
      if (im !== e.im) begin
        $display("%0t: equalized_im expected %0d actual %0d (sc %0d)", $time, e.im, im, e.sc);
        errors++;
      end
      if (sc !== e.sc) begin
        $display("%0t: subcarrier expected %0d actual %0d", $time, e.sc, sc);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_of_symbol expected %0b actual %0b (sc %0d)",
                 $time, e.last, last, e.sc);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;
  logic [0:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [39:0]          m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  eq_scoreboard sb = new();
  bit steady = 0;
  int stall_cycles = 0;

  preamble_channel_equalizer_top dut (.*);

  always #5 clk = ~clk;

  // receiver: stalls with a probability of about 12 percent unless in the steady stretch
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 12);
  end

  // monitors for accepted items and results, plus the stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32],
                      s_axis_tdata[63:48], s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[37:32],
                        m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // sender: present one item and hold it until accepted
  task automatic send_item(logic signed [15:0] s_re, s_im, r_re, r_im, logic alloc);
    if (!steady && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {r_im, r_re, s_im, s_re};
    s_axis_tuser  <= alloc;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(7))
      0: return 0;
      1: return $signed(16'($urandom_range(8))) - 4;
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_symbol();
    for (int k = 0; k < NUM_SC; k++)
      send_item(rand_value(), rand_value(), rand_value(), rand_value(),
                $urandom_range(9) != 0);
  endtask

  // fixed symbol: zero sample, tiny sample against a large reference,
  // unallocated carriers at 4, 5 and just below DC, and full-scale samples
  task automatic send_directed_symbol();
    logic signed [15:0] s_re, s_im, r_re, r_im;
    logic alloc;
    for (int k = 0; k < NUM_SC; k++) begin
      s_re = 16'sh4000; s_im = -16'sh2000; r_re = 16'sh2000; r_im = 16'sh1000; alloc = 1;
      case (k)
        0: begin s_re = 0; s_im = 0; end
        2: begin s_re = 1; s_im = 0; r_re = 16'sh7FFF; r_im = 16'sh8000; end
        4: alloc = 0;
        5: alloc = 0;
        6: begin s_re = 16'sh8000; s_im = 16'sh8000; r_re = 16'sh8000; r_im = 16'sh7FFF; end
        8: begin s_re = 16'sh7FFF; s_im = 16'sh7FFF; r_re = 16'sh7FFF; r_im = 16'sh7FFF; end
        10: begin s_re = -1; s_im = 1; r_re = 16'sh8000; r_im = 16'sh8000; end
        DC_SC - 1: alloc = 0;
        default: ;
      endcase
      send_item(s_re, s_im, r_re, r_im, alloc);
    end
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // registers change only with the block idle and drained
  task automatic configure(int unsigned est, int unsigned trans, int unsigned frame);
    wait_results();
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_we <= 1; cfg_index <= CFG_ESTIMATION_SYMBOL; cfg_data <= CFG_W'(est);
    sb.set_cfg(CFG_ESTIMATION_SYMBOL, est);
    @(posedge clk);
    cfg_index <= CFG_TRANSIENT_SYMBOLS; cfg_data <= CFG_W'(trans);
    sb.set_cfg(CFG_TRANSIENT_SYMBOLS, trans);
    @(posedge clk);
    cfg_index <= CFG_FRAME_SYMBOLS; cfg_data <= CFG_W'(frame);
    sb.set_cfg(CFG_FRAME_SYMBOLS, frame);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings: one transient symbol
    send_random_symbol();

    // shortest frame: estimation then one payload symbol
    configure(0, 1, 2);
    repeat (3) send_directed_symbol();
    repeat (3) send_random_symbol();

    configure(2, 3, 6);
    repeat (3) send_random_symbol();
    wait_results();
    repeat (3) send_random_symbol();

    // largest settings, then estimation symbol outside the transient part
    configure(1023, 1023, 2047);
    send_random_symbol();
    configure(5, 2, 4);
    repeat (4) send_random_symbol();

    // steady stretch with no idling on either side
    configure(0, 1, 2047);
    steady = 1;
    repeat (4) send_random_symbol();
    steady = 0;
    send_random_symbol();

    wait_results();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Sent %0d items over six register settings, checked %0d results.",
             sb.items, sb.results);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
